// File: src/fcpm_pkg.sv
// Package for the folded code point matcher.
// Widths, request and status codes, register map, folding helpers and config type.
// No dependencies.
`default_nettype none
package fcpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int IDX_W       = $clog2(PATTERN_MAX);
  localparam int LEN_W       = IDX_W + 1;
  localparam int CP_W        = 21;
  localparam int POS_W       = 26;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;

  typedef logic [CP_W-1:0]  cp_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [1:0]       req_t;
  typedef logic [2:0]       status_t;

  localparam pos_t SOURCE_MAX = 26'd33554432;
  localparam pos_t MAX_MATCHES_RST = 26'd33554432;
  localparam len_t LEN_CAP = LEN_W'(PATTERN_MAX);

  localparam req_t REQ_LOAD = 2'd0;
  localparam req_t REQ_SRC  = 2'd1;
  localparam req_t REQ_END  = 2'd2;

  localparam status_t ST_MATCH    = 3'd0;
  localparam status_t ST_DONE     = 3'd1;
  localparam status_t ST_TOO_MANY = 3'd2;
  localparam status_t ST_INVALID  = 3'd3;
  localparam status_t ST_EMPTY    = 3'd4;
  localparam status_t ST_TOO_LONG = 3'd5;

  localparam logic [2:0] REG_PAT_LEN   = 3'd0;
  localparam logic [2:0] REG_FOLD_FW   = 3'd1;
  localparam logic [2:0] REG_IGN_CASE  = 3'd2;
  localparam logic [2:0] REG_OVERLAP   = 3'd3;
  localparam logic [2:0] REG_STOP_1ST  = 3'd4;
  localparam logic [2:0] REG_MAX_MATCH = 3'd5;

  localparam cp_t CP_MAX      = 21'h10ffff;
  localparam cp_t SURR_LO     = 21'h00d800;
  localparam cp_t SURR_HI     = 21'h00dfff;
  localparam cp_t FW_DIG_LO   = 21'h00ff10;
  localparam cp_t FW_DIG_HI   = 21'h00ff19;
  localparam cp_t FW_UP_LO    = 21'h00ff21;
  localparam cp_t FW_UP_HI    = 21'h00ff3a;
  localparam cp_t FW_LO_LO    = 21'h00ff41;
  localparam cp_t FW_LO_HI    = 21'h00ff5a;
  localparam cp_t FW_OFFSET   = 21'h00fee0;
  localparam cp_t ASCII_A     = 21'h000041;
  localparam cp_t ASCII_Z     = 21'h00005a;
  localparam cp_t CASE_OFFSET = 21'h000020;

  typedef struct packed {
    len_t pattern_length;
    logic fold_fullwidth;
    logic ignore_case;
    logic allow_overlap;
    logic stop_after_first;
    pos_t max_matches;
  } cfg_t;

  function automatic logic cp_invalid(input cp_t c);
    return (c > CP_MAX) || ((c >= SURR_LO) && (c <= SURR_HI));
  endfunction

  function automatic cp_t fold_cp(input cp_t c, input logic fw, input logic ic);
    cp_t r;
    r = c;
    if (fw && (((r >= FW_DIG_LO) && (r <= FW_DIG_HI)) ||
               ((r >= FW_UP_LO) && (r <= FW_UP_HI)) ||
               ((r >= FW_LO_LO) && (r <= FW_LO_HI))))
      r = r - FW_OFFSET;
    if (ic && (r >= ASCII_A) && (r <= ASCII_Z))
      r = r + CASE_OFFSET;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/fcpm_in_if.sv
// Input channel interface: one request item per handshake.
// Depends on fcpm_pkg.
`default_nettype none
interface fcpm_in_if;
  import fcpm_pkg::*;
  logic valid;
  logic ready;
  req_t req_type;
  idx_t pattern_index;
  cp_t  code_point;

  modport source (output valid, req_type, pattern_index, code_point, input ready);
  modport sink   (input valid, req_type, pattern_index, code_point, output ready);
endinterface
`default_nettype wire

// File: src/fcpm_out_if.sv
// Result channel interface: one result item per handshake.
// Depends on fcpm_pkg.
`default_nettype none
interface fcpm_out_if;
  import fcpm_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  pos_t    match_start;
  pos_t    match_end;
  pos_t    match_count;

  modport source (output valid, status, match_start, match_end, match_count, input ready);
  modport sink   (input valid, status, match_start, match_end, match_count, output ready);
endinterface
`default_nettype wire

// File: src/fcpm_cfg.sv
// APB-style configuration register bank of the matcher.
// Depends on fcpm_pkg.
`default_nettype none
module fcpm_cfg (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire [fcpm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire [fcpm_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [fcpm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output fcpm_pkg::cfg_t              cfg
);
  import fcpm_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_sel    = cfg_paddr[ADDR_W-1:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_length   <= '0;
      cfg_r.fold_fullwidth   <= 1'b0;
      cfg_r.ignore_case      <= 1'b0;
      cfg_r.allow_overlap    <= 1'b0;
      cfg_r.stop_after_first <= 1'b0;
      cfg_r.max_matches      <= MAX_MATCHES_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PAT_LEN:   cfg_r.pattern_length   <= cfg_pwdata[LEN_W-1:0];
        REG_FOLD_FW:   cfg_r.fold_fullwidth   <= cfg_pwdata[0];
        REG_IGN_CASE:  cfg_r.ignore_case      <= cfg_pwdata[0];
        REG_OVERLAP:   cfg_r.allow_overlap    <= cfg_pwdata[0];
        REG_STOP_1ST:  cfg_r.stop_after_first <= cfg_pwdata[0];
        REG_MAX_MATCH: cfg_r.max_matches      <= cfg_pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PAT_LEN:   cfg_prdata = DATA_W'(cfg_r.pattern_length);
      REG_FOLD_FW:   cfg_prdata = DATA_W'(cfg_r.fold_fullwidth);
      REG_IGN_CASE:  cfg_prdata = DATA_W'(cfg_r.ignore_case);
      REG_OVERLAP:   cfg_prdata = DATA_W'(cfg_r.allow_overlap);
      REG_STOP_1ST:  cfg_prdata = DATA_W'(cfg_r.stop_after_first);
      REG_MAX_MATCH: cfg_prdata = DATA_W'(cfg_r.max_matches);
      default:       cfg_prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

// File: src/fcpm_match.sv
// Pattern store, source window shift line and parallel window compare.
// Depends on fcpm_pkg.
`default_nettype none
module fcpm_match (
  input  wire                  clk,
  input  wire                  pat_we,
  input  wire fcpm_pkg::idx_t  pat_idx,
  input  wire fcpm_pkg::cp_t   pat_cp,
  input  wire                  win_shift,
  input  wire fcpm_pkg::cp_t   src_cp,
  input  wire fcpm_pkg::len_t  len,
  input  wire fcpm_pkg::cfg_t  cfg,
  output logic                 hit
);
  import fcpm_pkg::*;

  cp_t pat_r [PATTERN_MAX];
  cp_t win_r [PATTERN_MAX];
  cp_t win_new [PATTERN_MAX];
  cp_t lvl [IDX_W+1][PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq;
  idx_t sh;

  always_ff @(posedge clk) begin
    if (pat_we)
      pat_r[pat_idx] <= pat_cp;
    if (win_shift)
      win_r <= win_new;
  end

  // newest character at tap 0
  always_comb begin
    win_new[0] = fold_cp(src_cp, cfg.fold_fullwidth, cfg.ignore_case);
    for (int k = 1; k < PATTERN_MAX; k++)
      win_new[k] = win_r[k-1];
  end

  // align so that slot i sees tap len-1-i: reverse, then shift by PATTERN_MAX-len
  assign sh = IDX_W'(LEN_CAP - len);

  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++)
      lvl[0][j] = win_new[PATTERN_MAX-1-j];
    for (int b = 0; b < IDX_W; b++) begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
        if (!sh[b])
          lvl[b+1][j] = lvl[b][j];
        else if (j + (1 << b) < PATTERN_MAX)
          lvl[b+1][j] = lvl[b][j + (1 << b)];
        else
          lvl[b+1][j] = '0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++)
      eq[i] = (LEN_W'(i) >= len) ||
              (lvl[IDX_W][i] == fold_cp(pat_r[i], cfg.fold_fullwidth, cfg.ignore_case));
  end

  assign hit = &eq;
endmodule
`default_nettype wire

// File: src/folded_code_point_matcher_top.sv
// Top level of the folded code point matcher: input register, match control, result register.
// Depends on fcpm_pkg, fcpm_in_if, fcpm_out_if, fcpm_cfg and fcpm_match.
// An accepted item waits in the input register; its result is written to the result register once that is free.
// Throughput: 1 item per cycle while the result register is free, set by the window compare and state update loop.
// Reset (rst_n low, synchronous): empties both registers, clears position, match
// count, halt and pattern error; config returns to its reset values.
`default_nettype none
module folded_code_point_matcher_top (
  input  wire                         clk,
  input  wire                         rst_n,
  fcpm_in_if.sink                     in_ch,
  fcpm_out_if.source                  out_ch,
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire [fcpm_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire [fcpm_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [fcpm_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import fcpm_pkg::*;

  cfg_t cfg;
  len_t len;
  logic hit;

  logic iv_r;
  req_t req_r;
  idx_t idx_r;
  cp_t  cp_r;

  logic    ov_r, ov_nxt;
  status_t st_r, st_nxt;
  pos_t    ms_r, ms_nxt;
  pos_t    me_r, me_nxt;
  pos_t    mc_r, mc_nxt;

  pos_t pos_r, pos_nxt;
  pos_t prev_r, prev_nxt;
  pos_t found_r, found_nxt;
  logic halted_r, halted_nxt;
  logic pend_r, pend_nxt;

  logic out_free, do_step, pat_we, win_shift;
  pos_t pos_inc, start;

  fcpm_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  assign len = (cfg.pattern_length > LEN_CAP) ? LEN_CAP : cfg.pattern_length;

  fcpm_match u_match (
    .clk, .pat_we, .pat_idx(idx_r), .pat_cp(cp_r), .win_shift, .src_cp(cp_r),
    .len, .cfg, .hit
  );

  assign out_free    = !ov_r || out_ch.ready;
  assign do_step     = iv_r && out_free;
  assign in_ch.ready = !iv_r || out_free;

  assign pos_inc = pos_r + 1'b1;
  assign start   = pos_inc - POS_W'(len);

  always_comb begin
    pos_nxt    = pos_r;
    prev_nxt   = prev_r;
    found_nxt  = found_r;
    halted_nxt = halted_r;
    pend_nxt   = pend_r;
    pat_we     = 1'b0;
    win_shift  = 1'b0;
    ov_nxt     = out_free ? 1'b0 : ov_r;
    st_nxt     = st_r;
    ms_nxt     = ms_r;
    me_nxt     = me_r;
    mc_nxt     = mc_r;
    if (do_step) begin
      st_nxt = ST_MATCH;
      ms_nxt = '0;
      me_nxt = '0;
      mc_nxt = found_r;
      if (req_r == REQ_LOAD) begin
        pat_we = 1'b1;
        if (cp_invalid(cp_r))
          pend_nxt = 1'b1;
      end else if ((req_r == REQ_SRC || req_r == REQ_END) && !halted_r) begin
        if (len == '0) begin
          ov_nxt = 1'b1; st_nxt = ST_EMPTY; halted_nxt = 1'b1;
        end else if (req_r == REQ_END) begin
          ov_nxt = 1'b1; halted_nxt = 1'b1;
          st_nxt = pend_r ? ST_INVALID : ST_DONE;
        end else if (pos_r >= SOURCE_MAX) begin
          ov_nxt = 1'b1; st_nxt = ST_TOO_LONG; halted_nxt = 1'b1;
        end else if (cp_invalid(cp_r) || pend_r) begin
          ov_nxt = 1'b1; st_nxt = ST_INVALID; halted_nxt = 1'b1;
        end else begin
          win_shift = 1'b1;
          pos_nxt   = pos_inc;
          if (!(cfg.stop_after_first && found_r != '0) && pos_inc >= POS_W'(len) && hit &&
              (cfg.allow_overlap || start >= prev_r)) begin
            ov_nxt = 1'b1;
            if (found_r == cfg.max_matches) begin
              st_nxt = ST_TOO_MANY; halted_nxt = 1'b1;
            end else begin
              found_nxt = found_r + 1'b1;
              prev_nxt  = pos_inc;
              ms_nxt    = start;
              me_nxt    = pos_inc;
              mc_nxt    = found_r + 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r     <= 1'b0;
      ov_r     <= 1'b0;
      pos_r    <= '0;
      prev_r   <= '0;
      found_r  <= '0;
      halted_r <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      if (in_ch.ready)
        iv_r <= in_ch.valid;
      ov_r     <= ov_nxt;
      pos_r    <= pos_nxt;
      prev_r   <= prev_nxt;
      found_r  <= found_nxt;
      halted_r <= halted_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req_r <= in_ch.req_type;
      idx_r <= in_ch.pattern_index;
      cp_r  <= in_ch.code_point;
    end
    st_r <= st_nxt;
    ms_r <= ms_nxt;
    me_r <= me_nxt;
    mc_r <= mc_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = st_r;
  assign out_ch.match_start = ms_r;
  assign out_ch.match_end   = me_r;
  assign out_ch.match_count = mc_r;
endmodule
`default_nettype wire

// File: src/fcpm_checker.sv
// Port-level checker for the matcher, bound to the top level.
// Depends on fcpm_pkg and folded_code_point_matcher_top.
`default_nettype none
module fcpm_checker (
  input wire                   clk,
  input wire                   rst_n,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire fcpm_pkg::status_t status,
  input wire fcpm_pkg::pos_t   m_start,
  input wire fcpm_pkg::pos_t   m_end,
  input wire fcpm_pkg::pos_t   m_count
);
  import fcpm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(m_count))
    else $error("result changed while stalled");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && status != ST_MATCH |=> !out_valid)
    else $error("result after done or error");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_MATCH |-> m_end > m_start && m_count != '0)
    else $error("bad match span or count");

  a_nopos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_MATCH |-> m_start == '0 && m_end == '0)
    else $error("positions on non-match result");
endmodule

bind folded_code_point_matcher_top fcpm_checker u_fcpm_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .m_start(out_ch.match_start), .m_end(out_ch.match_end),
  .m_count(out_ch.match_count)
);
`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for folded_code_point_matcher_top: drives pattern, source and end items,
// predicts each report from a shadow of pattern, window, counters and registers, checks results.
// Depends on fcpm_pkg, fcpm_in_if, fcpm_out_if and the top level.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fcpm_pkg::*;

  localparam req_t REQ_NONE     = 2'd3;
  localparam pos_t SOURCE_LIMIT = 26'd33554432;
  localparam int   IDLE_LIMIT   = 2000;

  localparam cp_t CP_TOP     = 21'h10ffff;
  localparam cp_t SURR_FIRST = 21'h00d800;
  localparam cp_t SURR_LAST  = 21'h00dfff;
  localparam cp_t FWD_0      = 21'h00ff10;
  localparam cp_t FWD_9      = 21'h00ff19;
  localparam cp_t FWU_A      = 21'h00ff21;
  localparam cp_t FWU_Z      = 21'h00ff3a;
  localparam cp_t FWL_A      = 21'h00ff41;
  localparam cp_t FWL_Z      = 21'h00ff5a;
  localparam cp_t FW_SHIFT   = 21'h00fee0;
  localparam cp_t UP_A       = 21'h000041;
  localparam cp_t UP_Z       = 21'h00005a;
  localparam cp_t CASE_SHIFT = 21'h000020;

  typedef struct packed {
    status_t status;
    pos_t    start_pos;
    pos_t    end_pos;
    pos_t    count;
  } match_rec_t;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  fcpm_in_if  in_ch();
  fcpm_out_if out_ch();

  folded_code_point_matcher_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the matcher
  cp_t        pattern_mem [32];
  cp_t        window_mem  [32];
  pos_t       src_count;
  pos_t       last_end;
  pos_t       match_total;
  logic       stopped;
  logic       bad_pattern;
  logic [5:0] len_reg;
  logic       fw_reg;
  logic       ic_reg;
  logic       overlap_reg;
  logic       first_reg;
  pos_t       limit_reg;

  match_rec_t expected_reports[$];
  int         mismatch_count = 0;
  bit         gaps_on = 1'b1;
  int         burst_left = 0;
  bit         hold_pending = 1'b0;
  logic [7:0] alphabet [5] = '{8'h61, 8'h62, 8'h7a, 8'h30, 8'h39};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic bad_code_point(input cp_t c);
    return (c > CP_TOP) || ((c >= SURR_FIRST) && (c <= SURR_LAST));
  endfunction

  function automatic cp_t fold_char(input cp_t c);
    cp_t r;
    r = c;
    if (fw_reg && (((r >= FWD_0) && (r <= FWD_9)) || ((r >= FWU_A) && (r <= FWU_Z)) ||
                   ((r >= FWL_A) && (r <= FWL_Z))))
      r = r - FW_SHIFT;
    if (ic_reg && (r >= UP_A) && (r <= UP_Z))
      r = r + CASE_SHIFT;
    return r;
  endfunction

  function automatic bit compute_report(input req_t rq, input idx_t ix, input cp_t cp,
                                        output match_rec_t rep);
    int   eff_len;
    int   k;
    pos_t first_pos;
    rep = '0;
    rep.count = match_total;
    eff_len = (len_reg > 6'd32) ? 32 : int'(len_reg);
    if (rq == REQ_LOAD) begin
      pattern_mem[ix] = cp;
      if (bad_code_point(cp)) bad_pattern = 1'b1;
      return 1'b0;
    end
    if ((rq == REQ_NONE) || stopped) return 1'b0;
    stopped = 1'b1;
    if (eff_len == 0) begin
      rep.status = ST_EMPTY;
      return 1'b1;
    end
    if (rq == REQ_END) begin
      rep.status = bad_pattern ? ST_INVALID : ST_DONE;
      return 1'b1;
    end
    if (src_count >= SOURCE_LIMIT) begin
      rep.status = ST_TOO_LONG;
      return 1'b1;
    end
    if (bad_code_point(cp) || bad_pattern) begin
      rep.status = ST_INVALID;
      return 1'b1;
    end
    stopped = 1'b0;
    for (k = 31; k > 0; k--) window_mem[k] = window_mem[k-1];
    window_mem[0] = fold_char(cp);
    src_count++;
    if (first_reg && (match_total != 0)) return 1'b0;
    if (src_count < eff_len) return 1'b0;
    for (k = 0; k < eff_len; k++)
      if (window_mem[k] != fold_char(pattern_mem[eff_len-1-k])) return 1'b0;
    first_pos = src_count - pos_t'(eff_len);
    if (!overlap_reg && (first_pos < last_end)) return 1'b0;
    if (match_total == limit_reg) begin
      stopped = 1'b1;
      rep.status = ST_TOO_MANY;
      return 1'b1;
    end
    match_total++;
    last_end = src_count;
    rep.status = ST_MATCH;
    rep.start_pos = first_pos;
    rep.end_pos = src_count;
    rep.count = match_total;
    return 1'b1;
  endfunction

  function automatic cp_t spell(input logic [7:0] ch);
    logic is_digit;
    is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    case ($urandom_range(0, 3))
      0: return cp_t'(ch);
      1: return is_digit ? cp_t'(ch) : cp_t'(ch - 8'h20);
      2: return is_digit ? FWD_0 + cp_t'(ch - 8'h30) : FWL_A + cp_t'(ch - 8'h61);
      default: return is_digit ? FWD_0 + cp_t'(ch - 8'h30) : FWU_A + cp_t'(ch - 8'h61);
    endcase
  endfunction

  function automatic cp_t rand_valid_cp();
    cp_t c;
    do c = cp_t'($urandom_range(0, CP_TOP)); while (bad_code_point(c));
    return c;
  endfunction

  function automatic cp_t rand_bad_cp();
    if ($urandom_range(0, 1)) return cp_t'($urandom_range(SURR_FIRST, SURR_LAST));
    return cp_t'($urandom_range(CP_TOP + 1, 21'h1fffff));
  endfunction

  task automatic send_item(input req_t rq, input idx_t ix, input cp_t cp);
    match_rec_t rep;
    if (gaps_on && (burst_left == 0)) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= rq;
    in_ch.pattern_index <= ix;
    in_ch.code_point    <= cp;
    do @(posedge clk); while (!in_ch.ready);
    if (compute_report(rq, ix, cp, rep)) expected_reports.push_back(rep);
  endtask

  task automatic send_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(REQ_SRC, idx_t'($urandom), cp_t'(s[k]));
  endtask

  task automatic load_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) send_item(REQ_LOAD, idx_t'(k), cp_t'(s[k]));
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_PAT_LEN:   len_reg     = value[5:0];
      REG_FOLD_FW:   fw_reg      = value[0];
      REG_IGN_CASE:  ic_reg      = value[0];
      REG_OVERLAP:   overlap_reg = value[0];
      REG_STOP_1ST:  first_reg   = value[0];
      REG_MAX_MATCH: limit_reg   = value[POS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [5:0] len_val, input logic fw, input logic ic,
                          input logic ovl, input logic first);
    wait_idle();
    write_reg(REG_PAT_LEN, 32'(len_val));
    write_reg(REG_FOLD_FW, 32'(fw));
    write_reg(REG_IGN_CASE, 32'(ic));
    write_reg(REG_OVERLAP, 32'(ovl));
    write_reg(REG_STOP_1ST, 32'(first));
  endtask

  // pattern copies in mixed spellings among noise, with some cut short
  task automatic run_stream(input int n_src, input int plen);
    logic [7:0] pat_base [32];
    int sent, r, k, cut;
    for (k = 0; k < plen; k++) begin
      pat_base[k] = alphabet[$urandom_range(0, 4)];
      send_item(REQ_LOAD, idx_t'(k), spell(pat_base[k]));
    end
    sent = 0;
    while (sent < n_src) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, plen - 1) : plen;
        for (k = 0; k < cut; k++) send_item(REQ_SRC, idx_t'($urandom), spell(pat_base[k]));
        sent += cut;
      end else if (r < 85) begin
        send_item(REQ_SRC, idx_t'($urandom), spell(alphabet[$urandom_range(0, 4)]));
        sent++;
      end else if (r < 90) begin
        send_item(REQ_SRC, idx_t'($urandom), rand_valid_cp());
        sent++;
      end else if (r < 96) begin
        k = $urandom_range(0, plen - 1);
        pat_base[k] = alphabet[$urandom_range(0, 4)];
        send_item(REQ_LOAD, idx_t'(k), spell(pat_base[k]));
      end else begin
        send_item(REQ_NONE, idx_t'($urandom), cp_t'($urandom));
      end
    end
  endtask

  task automatic test_pattern_load();
    int k;
    for (k = 0; k < 32; k++) send_item(REQ_LOAD, idx_t'(k), spell(alphabet[$urandom_range(0, 4)]));
    send_item(REQ_LOAD, idx_t'(31), CP_TOP);
    send_item(REQ_LOAD, idx_t'(30), 21'h0);
    send_item(REQ_NONE, idx_t'(31), 21'h1fffff);
    wait_idle();
    write_reg(REG_MAX_MATCH, 32'(SOURCE_LIMIT));
  endtask

  task automatic test_first_only();
    set_mode(6'd2, 1'b0, 1'b0, 1'b0, 1'b1);
    load_text("ab");
    send_text("zababAb");
  endtask

  task automatic test_fold_edges();
    cp_t probes [17] = '{21'h41, 21'h40, 21'h5a, 21'h5b, 21'h61, 21'hff21, 21'hff41,
                         21'hff40, 21'hff5a, 21'hff5b, 21'hff3a, 21'hff3b, 21'hff20,
                         21'h0, CP_TOP, 21'hd7ff, 21'he000};
    cp_t digits [5] = '{21'h30, 21'hff10, 21'hff0f, 21'hff19, 21'hff1a};
    set_mode(6'd1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(REQ_LOAD, idx_t'(0), 21'h61);
    foreach (probes[k]) send_item(REQ_SRC, idx_t'($urandom), probes[k]);
    send_item(REQ_LOAD, idx_t'(0), FWD_0);
    foreach (digits[k]) send_item(REQ_SRC, idx_t'($urandom), digits[k]);
  endtask

  task automatic test_overlap();
    set_mode(6'd3, 1'b0, 1'b0, 1'b1, 1'b0);
    load_text("aba");
    send_text("abababa");
    set_mode(6'd3, 1'b0, 1'b0, 1'b0, 1'b0);
    send_text("abababa");
  endtask

  task automatic test_long_pattern();
    int k;
    set_mode(6'd32, 1'b1, 1'b1, 1'b1, 1'b0);
    for (k = 0; k < 32; k++) send_item(REQ_LOAD, idx_t'(k), spell(8'h61));
    for (k = 0; k < 40; k++) send_item(REQ_SRC, idx_t'($urandom), spell(8'h61));
    set_mode(6'd63, 1'b1, 1'b1, 1'b0, 1'b0);
    for (k = 0; k < 70; k++) send_item(REQ_SRC, idx_t'($urandom), spell(8'h61));
  endtask

  task automatic test_backpressure();
    int k;
    set_mode(6'd1, 1'b0, 1'b0, 1'b1, 1'b0);
    send_item(REQ_LOAD, idx_t'(0), 21'h61);
    gaps_on = 1'b0;
    hold_pending = 1'b1;
    for (k = 0; k < 40; k++) send_item(REQ_SRC, idx_t'($urandom), 21'h61);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int phase, lsel, plen;
    logic [5:0] len_val;
    logic [31:0] lim;
    for (phase = 0; phase < 7; phase++) begin
      lsel = $urandom_range(0, 9);
      if (lsel < 8) len_val = 6'($urandom_range(1, 5));
      else if (lsel == 8) len_val = 6'($urandom_range(6, 32));
      else len_val = 6'($urandom_range(33, 63));
      plen = (len_val > 6'd32) ? 32 : int'(len_val);
      set_mode(len_val, 1'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 6) == 0);
      if ($urandom_range(0, 2) == 0) begin
        // never equal to a count this phase can reach
        case ($urandom_range(0, 2))
          0: lim = 32'(SOURCE_LIMIT);
          1: lim = (match_total != 0) ? 32'd0 : 32'h3ffffff;
          default: lim = $urandom_range(32'(match_total) + 1000, 32'h3ffffff);
        endcase
        write_reg(REG_MAX_MATCH, lim);
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      run_stream((plen > 8) ? 100 : 70, plen);
    end
    gaps_on = 1'b1;
  endtask

  // one run can end only once; choose how, then check that everything after is ignored
  task automatic test_terminal();
    int k;
    case ($urandom_range(0, 4))
      0: send_item(REQ_END, idx_t'($urandom), cp_t'($urandom));
      1: begin
        set_mode(6'd1, 1'b0, 1'b0, 1'b1, 1'b0);
        write_reg(REG_MAX_MATCH, 32'(match_total));
        send_item(REQ_LOAD, idx_t'(0), 21'h7a);
        send_item(REQ_SRC, idx_t'($urandom), 21'h7a);
      end
      2: send_item(REQ_SRC, idx_t'($urandom), rand_bad_cp());
      3: begin
        send_item(REQ_LOAD, idx_t'($urandom), rand_bad_cp());
        if ($urandom_range(0, 1)) send_item(REQ_SRC, idx_t'($urandom), rand_valid_cp());
        else send_item(REQ_END, idx_t'($urandom), cp_t'($urandom));
      end
      default: begin
        set_mode(6'd0, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
        if ($urandom_range(0, 1)) send_item(REQ_LOAD, idx_t'($urandom), rand_bad_cp());
        if ($urandom_range(0, 1)) send_item(REQ_SRC, idx_t'($urandom), rand_bad_cp());
        else send_item(REQ_END, idx_t'($urandom), cp_t'($urandom));
      end
    endcase
    for (k = 0; k < 12; k++)
      send_item(req_t'($urandom_range(0, 3)), idx_t'($urandom), cp_t'($urandom));
  endtask

  // result checker and receiver stall pattern
  initial begin
    match_rec_t want;
    int run_left, stall_left, hold_left;
    run_left = 0;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result item: status %0d", out_ch.status);
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_ch.status);
            mismatch_count++;
          end
          if (out_ch.match_start !== want.start_pos) begin
            $error("match_start: expected %0d, actual %0d", want.start_pos, out_ch.match_start);
            mismatch_count++;
          end
          if (out_ch.match_end !== want.end_pos) begin
            $error("match_end: expected %0d, actual %0d", want.end_pos, out_ch.match_end);
            mismatch_count++;
          end
          if (out_ch.match_count !== want.count) begin
            $error("match_count: expected %0d, actual %0d", want.count, out_ch.match_count);
            mismatch_count++;
          end
        end
      end
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
        stall_left = $urandom_range(0, 4);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_psel && cfg_penable && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL folded_code_point_matcher_top");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k < 32; k++) begin
      pattern_mem[k] = '0;
      window_mem[k] = '0;
    end
    src_count   = '0;
    last_end    = '0;
    match_total = '0;
    stopped     = 1'b0;
    bad_pattern = 1'b0;
    len_reg     = '0;
    fw_reg      = 1'b0;
    ic_reg      = 1'b0;
    overlap_reg = 1'b0;
    first_reg   = 1'b0;
    limit_reg   = SOURCE_LIMIT;
    in_ch.valid         <= 1'b0;
    in_ch.req_type      <= REQ_NONE;
    in_ch.pattern_index <= '0;
    in_ch.code_point    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pattern_load();
    test_first_only();
    test_fold_edges();
    test_overlap();
    test_long_pattern();
    test_backpressure();
    test_random_phases();
    test_terminal();

    wait_idle();
    repeat (10) @(posedge clk);
    if ((mismatch_count == 0) && (expected_reports.size() == 0))
      $display("PASS folded_code_point_matcher_top");
    else
      $display("FAIL folded_code_point_matcher_top");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
src/fcpm_pkg.sv
src/fcpm_in_if.sv
src/fcpm_out_if.sv
src/fcpm_cfg.sv
src/fcpm_match.sv
src/folded_code_point_matcher_top.sv
src/fcpm_checker.sv
bench/testbench.sv
